@@ rtl/key_click_longpress_detector_defines.svh @@
// Assertion macros shared by the key detector checker.
`ifndef KEY_CLICK_LONGPRESS_DETECTOR_DEFINES_SVH
`define KEY_CLICK_LONGPRESS_DETECTOR_DEFINES_SVH

// Concurrent assertion on i_clk, disabled while i_rst_n is low
`define KCLD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Concurrent assertion on i_clk that also holds during reset
`define KCLD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/kcld_pkg.sv @@
// Shared constants for the key click / long press detector.
`timescale 1ns / 1ps
package kcld_pkg;

    // Field widths fixed by the stream format
    localparam int PORT_W  = 3;
    localparam int EVENT_W = 5;
    localparam int TIME_W  = 16;
    localparam int CLICK_W = 4;

    localparam logic [CLICK_W-1:0] CLICK_MAX  = 4'd15;
    localparam logic [EVENT_W-1:0] EVENT_LONG = 5'd16;
    localparam logic [TIME_W-1:0]  TIME_MAX   = 16'hFFFF;

    // Configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_PIN_MASK    = 3'd0;
    localparam logic [2:0] REG_PORT_ENABLE = 3'd1;
    localparam logic [2:0] REG_TICK_PERIOD = 3'd2;
    localparam logic [2:0] REG_OVER_TIME   = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd4;

endpackage

@@ rtl/key_click_longpress_detector.sv @@
// A scan tick is held in the input register and its result in the result register.
// One scan tick per cycle unless the result stream stalls; the selected port's state
// entry is read, updated and written back between the input and result registers.
// A stalled result transaction holds the input register and drops s_axis_tready.
// Reset (synchronous, active low) clears all port state, restores the register
// defaults and empties both stream registers.
`timescale 1ns / 1ps
module key_click_longpress_detector
    import kcld_pkg::*;
#(
    parameter int PORTS     = 8,
    parameter int PIN_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Scan tick stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: port_index[2:0], pin_levels[PIN_WIDTH+2:3], zero fill
    input  logic [((PORT_W+PIN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: out_port[2:0], event_code[7:3], pressed_pins[PIN_WIDTH+7:8],
    //        press_time_ms[PIN_WIDTH+23:PIN_WIDTH+8], zero fill
    output logic [((PORT_W+EVENT_W+PIN_WIDTH+TIME_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: notify[0], released[1]
    output logic [1:0]             m_axis_tuser
);

    localparam int OUT_W = ((PORT_W + EVENT_W + PIN_WIDTH + TIME_W + 7) / 8) * 8;
    localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // Configuration registers
    logic [31:0]       r_pin_mask;
    logic [7:0]        r_port_enable;
    logic [TIME_W-1:0] r_tick_period;
    logic [TIME_W-1:0] r_over_time;
    logic [TIME_W-1:0] r_long_press;

    logic       w_cfg_wr;
    logic [2:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_mask    <= 32'd1;
            r_port_enable <= 8'd0;
            r_tick_period <= 16'd10;
            r_over_time   <= 16'd200;
            r_long_press  <= 16'd1000;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_PIN_MASK:    r_pin_mask    <= pwdata;
                REG_PORT_ENABLE: r_port_enable <= pwdata[7:0];
                REG_TICK_PERIOD: r_tick_period <= pwdata[TIME_W-1:0];
                REG_OVER_TIME:   r_over_time   <= pwdata[TIME_W-1:0];
                REG_LONG_PRESS:  r_long_press  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_cfg_idx)
            REG_PIN_MASK:    prdata = r_pin_mask;
            REG_PORT_ENABLE: prdata = {24'd0, r_port_enable};
            REG_TICK_PERIOD: prdata = {16'd0, r_tick_period};
            REG_OVER_TIME:   prdata = {16'd0, r_over_time};
            REG_LONG_PRESS:  prdata = {16'd0, r_long_press};
            default:         prdata = 32'd0;
        endcase
    end

    // Input register and pipeline advance
    logic                 r_in_valid;
    logic [PORT_W-1:0]    r_port;
    logic [PIN_WIDTH-1:0] r_levels;
    logic                 r_out_valid;
    logic                 w_advance;

    assign w_advance     = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_port   <= s_axis_tdata[PORT_W-1:0];
            r_levels <= s_axis_tdata[PORT_W +: PIN_WIDTH];
        end
    end

    // Per-port state
    logic [PORTS-1:0]     r_key_down;
    logic [PORTS-1:0]     r_release_seen;
    logic [CLICK_W-1:0]   r_click_count  [PORTS];
    logic [PIN_WIDTH-1:0] r_saved_levels [PORTS];
    logic [TIME_W-1:0]    r_elapsed      [PORTS];
    logic [EVENT_W-1:0]   r_report_event [PORTS];
    logic [PIN_WIDTH-1:0] r_report_pins  [PORTS];
    logic [TIME_W-1:0]    r_report_time  [PORTS];

    logic [IDX_W-1:0]     w_idx;
    logic                 w_port_ok;
    logic                 w_active;
    logic [PIN_WIDTH-1:0] w_mask;
    logic [PIN_WIDTH-1:0] w_m;
    logic [TIME_W:0]      w_sum;
    logic [TIME_W-1:0]    w_sat;
    logic [TIME_W:0]      w_limit;
    logic                 w_ended;

    logic                 n_down;
    logic                 n_rs;
    logic [CLICK_W-1:0]   n_cc;
    logic [PIN_WIDTH-1:0] n_saved;
    logic [TIME_W-1:0]    n_elapsed;
    logic [EVENT_W-1:0]   n_rev;
    logic [PIN_WIDTH-1:0] n_rpins;
    logic [TIME_W-1:0]    n_rtime;
    logic                 n_notify;
    logic                 n_rel;

    assign w_idx     = IDX_W'(r_port);
    assign w_port_ok = (32'(r_port) < PORTS);
    assign w_mask    = r_pin_mask[PIN_WIDTH-1:0];
    assign w_m       = r_levels & w_mask;
    assign w_active  = w_port_ok & r_port_enable[r_port] & (|w_mask);
    assign w_sum     = {1'b0, r_elapsed[w_idx]} + {1'b0, r_tick_period};
    assign w_sat     = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
    assign w_limit   = {1'b0, r_report_time[w_idx]} + {1'b0, r_over_time};

    // Next state of the scanned port
    always_comb begin
        n_down    = r_key_down[w_idx];
        n_rs      = r_release_seen[w_idx];
        n_cc      = r_click_count[w_idx];
        n_saved   = r_saved_levels[w_idx];
        n_elapsed = r_elapsed[w_idx];
        n_rev     = r_report_event[w_idx];
        n_rpins   = r_report_pins[w_idx];
        n_rtime   = r_report_time[w_idx];
        n_notify  = 1'b0;
        n_rel     = 1'b0;
        w_ended   = 1'b0;
        if (w_active) begin
            if (!r_key_down[w_idx]) begin
                // Up mode: any masked pin low starts a press
                n_rs    = 1'b0;
                n_saved = w_m;
                n_down  = (w_m != w_mask);
                n_cc    = (w_m != w_mask) ? CLICK_W'(1) : '0;
            end else begin
                n_elapsed = w_sat;
                if (w_m == w_mask) begin
                    n_rs = 1'b1;
                    // Release long enough: detection is over
                    if ({1'b0, w_sat} >= w_limit) begin
                        w_ended   = 1'b1;
                        n_rs      = 1'b0;
                        n_down    = 1'b0;
                        n_rev     = (r_report_time[w_idx] > r_long_press) ?
                                    EVENT_LONG : {1'b0, r_click_count[w_idx]};
                        n_notify  = 1'b1;
                        n_rel     = 1'b1;
                        n_elapsed = '0;
                    end
                end else begin
                    n_rpins  = ~r_levels & w_mask;
                    n_rtime  = w_sat;
                    n_notify = 1'b1;
                end
                // Same pins pressed again after a release: one more click
                if (!w_ended && (w_m == r_saved_levels[w_idx]) && n_rs) begin
                    if (n_cc < CLICK_MAX) begin
                        n_cc = n_cc + CLICK_W'(1);
                    end
                    n_rs = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down     <= '0;
            r_release_seen <= '0;
            for (int i = 0; i < PORTS; i++) begin
                r_click_count[i]  <= '0;
                r_saved_levels[i] <= '0;
                r_elapsed[i]      <= '0;
                r_report_event[i] <= '0;
                r_report_pins[i]  <= '0;
                r_report_time[i]  <= '0;
            end
        end else if (w_advance && w_port_ok) begin
            r_key_down[w_idx]     <= n_down;
            r_release_seen[w_idx] <= n_rs;
            r_click_count[w_idx]  <= n_cc;
            r_saved_levels[w_idx] <= n_saved;
            r_elapsed[w_idx]      <= n_elapsed;
            r_report_event[w_idx] <= n_rev;
            r_report_pins[w_idx]  <= n_rpins;
            r_report_time[w_idx]  <= n_rtime;
        end
    end

    // Result register
    logic [PORT_W-1:0]    r_out_port;
    logic                 r_out_notify;
    logic                 r_out_rel;
    logic [EVENT_W-1:0]   r_out_event;
    logic [PIN_WIDTH-1:0] r_out_pins;
    logic [TIME_W-1:0]    r_out_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_port   <= r_port;
            r_out_notify <= n_notify;
            r_out_rel    <= n_rel;
            // Out-of-range port reports zero event, pins and time
            r_out_event  <= w_port_ok ? n_rev   : '0;
            r_out_pins   <= w_port_ok ? n_rpins : '0;
            r_out_time   <= w_port_ok ? n_rtime : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out_rel, r_out_notify};
    assign m_axis_tdata  = OUT_W'({r_out_time, r_out_pins, r_out_event, r_out_port});

endmodule

@@ rtl/kcld_checker.sv @@
// Port-level checker for the key detector, bound to the top level.
`timescale 1ns / 1ps
`include "key_click_longpress_detector_defines.svh"
module kcld_checker
    import kcld_pkg::*;
#(
    parameter int PIN_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   pready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [((PORT_W+EVENT_W+PIN_WIDTH+TIME_W+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    // A stalled result transaction keeps its payload
    `KCLD_ASSERT_RST(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Release end always notifies
    `KCLD_ASSERT_RST(a_rel_notify, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0], "released without notify")

    // Event code is a click count or long press
    `KCLD_ASSERT_RST(a_event_range, m_axis_tvalid |-> m_axis_tdata[7:3] <= EVENT_LONG, "event code out of range")

    // Configuration port never waits
    `KCLD_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind key_click_longpress_detector kcld_checker #(
    .PIN_WIDTH(PIN_WIDTH)
) u_kcld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
